// ===== rtl/core/wsp_pkg.sv =====
`default_nettype none

package wsp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_BAD_TAG   = 2'd0;
  localparam logic [1:0] ERR_NO_FORMAT = 2'd1;
  localparam logic [1:0] ERR_SHORT_FMT = 2'd2;

  // Chunk tags as they sit in the shift register (first byte lowest)
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [7:0] PCM_OFFSET = 8'h80;

  // Unsigned divide by three: (x * RECIP3) >> 33 is exact for 32-bit x
  localparam logic [31:0] RECIP3      = 32'hAAAA_AAAB;
  localparam int          RECIP3_SHIFT = 33;

  // Queue between parser and formatter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_FILEHDR,
    PH_SUBHDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } byte_item_t;

  typedef struct packed {
    logic        [1:0]  result_kind;
    logic signed [15:0] sample_value;
    logic        [15:0] channel_count;
    logic        [31:0] rate_hz;
    logic        [31:0] sample_total;
    logic        [1:0]  error_code;
  } result_item_t;

  // Queue entry: a result whose sample_total still holds the raw data size
  // for format results, plus the sample size that divides it.
  typedef struct packed {
    result_item_t res;
    logic [2:0]   size_bytes;
  } queue_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/wsp_front.sv =====
`default_nettype none

module wsp_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire wsp_pkg::byte_item_t  byte_item,
  input  wire logic                 queue_full,
  output logic                      push,
  output wsp_pkg::queue_entry_t     push_entry
);

  wsp_pkg::phase_t phase, phase_next, cur_phase;
  logic [3:0]  hdr_idx, hdr_idx_next, cur_hdr_idx;
  logic [31:0] tag_shift, tag_shift_next, cur_tag_shift;
  logic [31:0] chunk_rem, chunk_rem_next, cur_chunk_rem;
  logic [23:0] collect, collect_next, cur_collect;
  logic [1:0]  sbi, sbi_next, cur_sbi;
  logic [12:0] size_bytes, size_bytes_next, cur_size_bytes;
  logic [15:0] channels, channels_next, cur_channels;
  logic [31:0] rate, rate_next, cur_rate;
  logic        fmt_seen, fmt_seen_next, cur_fmt_seen;
  logic        emit;
  logic        accept;
  logic [7:0]  b;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;
  assign push       = accept && emit;
  assign b          = byte_item.data_byte;

  always_comb begin
    // A first byte restarts from the cleared state
    cur_phase      = byte_item.first_byte ? wsp_pkg::PH_FILEHDR : phase;
    cur_hdr_idx    = byte_item.first_byte ? '0 : hdr_idx;
    cur_tag_shift  = byte_item.first_byte ? '0 : tag_shift;
    cur_chunk_rem  = byte_item.first_byte ? '0 : chunk_rem;
    cur_collect    = byte_item.first_byte ? '0 : collect;
    cur_sbi        = byte_item.first_byte ? '0 : sbi;
    cur_size_bytes = byte_item.first_byte ? '0 : size_bytes;
    cur_channels   = byte_item.first_byte ? '0 : channels;
    cur_rate       = byte_item.first_byte ? '0 : rate;
    cur_fmt_seen   = byte_item.first_byte ? 1'b0 : fmt_seen;

    phase_next      = cur_phase;
    hdr_idx_next    = cur_hdr_idx;
    tag_shift_next  = cur_tag_shift;
    chunk_rem_next  = cur_chunk_rem;
    collect_next    = cur_collect;
    sbi_next        = cur_sbi;
    size_bytes_next = cur_size_bytes;
    channels_next   = cur_channels;
    rate_next       = cur_rate;
    fmt_seen_next   = cur_fmt_seen;
    emit            = 1'b0;
    push_entry      = '0;

    case (cur_phase)
      wsp_pkg::PH_FILEHDR: begin
        tag_shift_next = {b, cur_tag_shift[31:8]};
        hdr_idx_next   = cur_hdr_idx + 4'd1;
        if (cur_hdr_idx == 4'd3 && tag_shift_next != wsp_pkg::TAG_RIFF) begin
          phase_next                      = wsp_pkg::PH_HALT;
          emit                            = 1'b1;
          push_entry.res.result_kind      = wsp_pkg::KIND_ERROR;
          push_entry.res.error_code       = wsp_pkg::ERR_BAD_TAG;
        end else if (cur_hdr_idx == 4'd11) begin
          if (tag_shift_next != wsp_pkg::TAG_WAVE) begin
            phase_next                    = wsp_pkg::PH_HALT;
            emit                          = 1'b1;
            push_entry.res.result_kind    = wsp_pkg::KIND_ERROR;
            push_entry.res.error_code     = wsp_pkg::ERR_BAD_TAG;
          end else begin
            phase_next   = wsp_pkg::PH_SUBHDR;
            hdr_idx_next = '0;
          end
        end
      end

      wsp_pkg::PH_SUBHDR: begin
        if (cur_hdr_idx < 4'd4) tag_shift_next = {b, cur_tag_shift[31:8]};
        else                    chunk_rem_next = {b, cur_chunk_rem[31:8]};
        hdr_idx_next = cur_hdr_idx + 4'd1;
        if (cur_hdr_idx == 4'd7) begin
          hdr_idx_next = '0;
          if (cur_tag_shift == wsp_pkg::TAG_FMT) begin
            if (chunk_rem_next < 32'd16) begin
              phase_next                  = wsp_pkg::PH_HALT;
              emit                        = 1'b1;
              push_entry.res.result_kind  = wsp_pkg::KIND_ERROR;
              push_entry.res.error_code   = wsp_pkg::ERR_SHORT_FMT;
            end else begin
              phase_next = wsp_pkg::PH_FMT;
            end
          end else if (cur_tag_shift == wsp_pkg::TAG_DATA) begin
            if (!cur_fmt_seen || cur_size_bytes < 13'd1 || cur_size_bytes > 13'd4) begin
              phase_next                  = wsp_pkg::PH_HALT;
              emit                        = 1'b1;
              push_entry.res.result_kind  = wsp_pkg::KIND_ERROR;
              push_entry.res.error_code   = wsp_pkg::ERR_NO_FORMAT;
            end else begin
              phase_next                   = wsp_pkg::PH_DATA;
              sbi_next                     = '0;
              collect_next                 = '0;
              emit                         = 1'b1;
              push_entry.res.result_kind   = wsp_pkg::KIND_FORMAT;
              push_entry.res.channel_count = cur_channels;
              push_entry.res.rate_hz       = cur_rate;
              push_entry.res.sample_total  = chunk_rem_next;
              push_entry.size_bytes        = cur_size_bytes[2:0];
            end
          end else begin
            phase_next = (chunk_rem_next == '0) ? wsp_pkg::PH_SUBHDR : wsp_pkg::PH_SKIP;
          end
        end
      end

      wsp_pkg::PH_FMT: begin
        chunk_rem_next = cur_chunk_rem - 32'd1;
        if (cur_hdr_idx == 4'd2) begin
          channels_next = {8'h00, b};
        end else if (cur_hdr_idx == 4'd3) begin
          channels_next = {b, cur_channels[7:0]};
        end else if (cur_hdr_idx >= 4'd4 && cur_hdr_idx <= 4'd7) begin
          rate_next = {b, cur_rate[31:8]};
        end else if (cur_hdr_idx == 4'd14) begin
          tag_shift_next = {24'h0, b};
        end else if (cur_hdr_idx == 4'd15) begin
          // bits per sample / 8
          size_bytes_next = {b, cur_tag_shift[7:3]};
          fmt_seen_next   = 1'b1;
        end
        hdr_idx_next = cur_hdr_idx + 4'd1;
        if (cur_hdr_idx == 4'd15) begin
          hdr_idx_next = '0;
          phase_next   = (chunk_rem_next == '0) ? wsp_pkg::PH_SUBHDR : wsp_pkg::PH_SKIP;
        end
      end

      wsp_pkg::PH_SKIP: begin
        chunk_rem_next = cur_chunk_rem - 32'd1;
        if (chunk_rem_next == '0) begin
          phase_next   = wsp_pkg::PH_SUBHDR;
          hdr_idx_next = '0;
        end
      end

      wsp_pkg::PH_DATA: begin
        if (cur_chunk_rem == '0) begin
          phase_next = wsp_pkg::PH_HALT;
        end else begin
          chunk_rem_next = cur_chunk_rem - 32'd1;
          collect_next   = {b, cur_collect[23:8]};
          if (({11'd0, cur_sbi} + 13'd1) < cur_size_bytes) begin
            sbi_next = cur_sbi + 2'd1;
          end else begin
            sbi_next                   = '0;
            emit                       = 1'b1;
            push_entry.res.result_kind = wsp_pkg::KIND_SAMPLE;
            if (cur_size_bytes == 13'd1)
              push_entry.res.sample_value = signed'({b ^ wsp_pkg::PCM_OFFSET, 8'h00});
            else
              push_entry.res.sample_value = signed'(collect_next[23:8]);
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wsp_pkg::PH_FILEHDR;
      hdr_idx    <= '0;
      tag_shift  <= '0;
      chunk_rem  <= '0;
      collect    <= '0;
      sbi        <= '0;
      size_bytes <= '0;
      channels   <= '0;
      rate       <= '0;
      fmt_seen   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      hdr_idx    <= hdr_idx_next;
      tag_shift  <= tag_shift_next;
      chunk_rem  <= chunk_rem_next;
      collect    <= collect_next;
      sbi        <= sbi_next;
      size_bytes <= size_bytes_next;
      channels   <= channels_next;
      rate       <= rate_next;
      fmt_seen   <= fmt_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wsp_queue.sv =====
`default_nettype none

module wsp_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire wsp_pkg::queue_entry_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       not_empty,
  output wsp_pkg::queue_entry_t      pop_entry
);

  wsp_pkg::queue_entry_t mem [wsp_pkg::QUEUE_DEPTH];
  logic [wsp_pkg::QPTR_W-1:0] wptr, rptr;
  logic [wsp_pkg::QPTR_W:0]   count;

  assign full      = (count == (wsp_pkg::QPTR_W+1)'(wsp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wsp_back.sv =====
`default_nettype none

module wsp_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  not_empty,
  input  wire wsp_pkg::queue_entry_t pop_entry,
  output logic                       pop,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output wsp_pkg::result_item_t      result_item
);

  wsp_pkg::queue_entry_t work;
  logic                  work_valid;
  logic                  out_load;
  logic [63:0]           prod;
  logic [31:0]           quotient;
  wsp_pkg::result_item_t formatted;

  assign out_load = work_valid && (!result_valid || !result_stall);
  assign pop      = not_empty && (!work_valid || out_load);

  // Sample count = data size / bytes per sample
  assign prod = 64'(work.res.sample_total) * 64'(wsp_pkg::RECIP3);

  always_comb begin
    case (work.size_bytes)
      3'd2:    quotient = {1'b0, work.res.sample_total[31:1]};
      3'd3:    quotient = prod[wsp_pkg::RECIP3_SHIFT +: 31] == '0 ? 32'd0
                        : {1'b0, prod[wsp_pkg::RECIP3_SHIFT +: 31]};
      3'd4:    quotient = {2'b00, work.res.sample_total[31:2]};
      default: quotient = work.res.sample_total;
    endcase
    formatted = work.res;
    if (work.res.result_kind == wsp_pkg::KIND_FORMAT) formatted.sample_total = quotient;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop)           work_valid <= 1'b1;
      else if (out_load) work_valid <= 1'b0;
      if (out_load)          result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop)      work        <= pop_entry;
    if (out_load) result_item <= formatted;
  end

endmodule

`default_nettype wire

// ===== rtl/core/wav_stream_pcm_decoder.sv =====
// Channel | Direction | Handshake                  | Payload
// byte    | in        | byte_valid / byte_stall     | wsp_pkg::byte_item_t (data_byte, first_byte)
// result  | out       | result_valid / result_stall | wsp_pkg::result_item_t
//
// Flow: the parser takes one byte per cycle while byte_stall is low; a result passes
// through the queue, the work register and the output register, one per cycle at most.
// The format result divides the data size by the sample size between the work and
// output registers: by shifts for two or four bytes, for three through a 32x32 reciprocal multiplier.
// Stalls: byte_stall rises only while the four-entry result queue is full.
// Reset: rst is synchronous and clears parser state, queue and the output valid flag.
`default_nettype none

module wav_stream_pcm_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire wsp_pkg::byte_item_t  byte_item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output wsp_pkg::result_item_t     result_item
);

  // Front/back hand-off
  logic                  push;
  logic                  queue_full;
  logic                  pop;
  logic                  queue_not_empty;
  wsp_pkg::queue_entry_t push_entry;
  wsp_pkg::queue_entry_t pop_entry;

  // Parse each byte and queue any result it causes
  wsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold results until the formatter drains them
  wsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_not_empty),
    .pop_entry  (pop_entry)
  );

  // Finish the sample count and drive the output register
  wsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (queue_not_empty),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

`default_nettype wire

// ===== rtl/core/wsp_checker.sv =====
`default_nettype none

module wsp_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  result_valid,
  input wire logic                  result_stall,
  input wire wsp_pkg::result_item_t result_item
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_item))
    else $error("result changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.result_kind <= wsp_pkg::KIND_ERROR)
    else $error("undefined result kind");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.result_kind == wsp_pkg::KIND_SAMPLE |->
      result_item.channel_count == '0 && result_item.rate_hz == '0 &&
      result_item.sample_total == '0 && result_item.error_code == '0)
    else $error("sample result carries format or error fields");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.result_kind == wsp_pkg::KIND_ERROR |->
      result_item.error_code <= wsp_pkg::ERR_SHORT_FMT &&
      result_item.sample_value == '0 && result_item.sample_total == '0)
    else $error("malformed error result");

endmodule

bind wav_stream_pcm_decoder wsp_checker u_wsp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);

`default_nettype wire
